[src/kde_pkg.sv]
`timescale 1ns / 1ps

package kde_pkg;

    localparam int KDE_MAX_CHARS = 7;
    localparam int MANT_W        = 24;
    localparam int PLACES_W      = 3;
    localparam int COUNT_W       = 3;
    localparam int CODE_W        = 4;
    localparam int PC_W          = 3;

    localparam logic [CODE_W-1:0] KC_ZERO  = 4'd0;
    localparam logic [CODE_W-1:0] KC_NINE  = 4'd9;
    localparam logic [CODE_W-1:0] KC_POINT = 4'd10;
    localparam logic [CODE_W-1:0] KC_ENTER = 4'd11;
    localparam logic [CODE_W-1:0] KC_BACK  = 4'd12;
    localparam logic [CODE_W-1:0] KC_FILL  = 4'd13;

    localparam logic [CODE_W-1:0] KEY_MAP [16] = '{
        4'd1,     4'd2, 4'd3,     KC_FILL,
        4'd4,     4'd5, 4'd6,     KC_BACK,
        4'd7,     4'd8, 4'd9,     KC_FILL,
        KC_POINT, 4'd0, KC_ENTER, KC_FILL
    };

    localparam logic [PC_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [PC_W-1:0] STEP_EDIT  = 3'd1;
    localparam logic [PC_W-1:0] STEP_TEST  = 3'd2;
    localparam logic [PC_W-1:0] STEP_ACCUM = 3'd3;
    localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;
    localparam logic [PC_W-1:0] STEP_HOLD  = 3'd5;

    typedef struct packed {
        logic       key_flag;
        logic [3:0] row_lines;
        logic [3:0] col_lines;
    } t_in_item;

    typedef struct packed {
        logic [MANT_W-1:0]   mantissa;
        logic [PLACES_W-1:0] decimal_places;
        logic                confirmed;
        logic [COUNT_W-1:0]  char_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_LOOP_DONE,
        CND_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic            take;
        logic            edit;
        logic            accum;
        logic            emit;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic loop_done;
        logic out_free;
    } t_status;

    function automatic t_ctrl ucode(logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{take: 1'b0, edit: 1'b0, accum: 1'b0, emit: 1'b0,
              cond: CND_ALWAYS, target: STEP_FETCH};
        unique case (pc)
            STEP_FETCH: begin
                w.take   = 1'b1;
                w.cond   = CND_NO_INPUT;
                w.target = STEP_FETCH;
            end
            STEP_EDIT: begin
                w.edit = 1'b1;
                w.cond = CND_NEXT;
            end
            STEP_TEST: begin
                w.cond   = CND_LOOP_DONE;
                w.target = STEP_EMIT;
            end
            STEP_ACCUM: begin
                w.accum  = 1'b1;
                w.cond   = CND_ALWAYS;
                w.target = STEP_TEST;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = CND_OUT_FREE;
                w.target = STEP_FETCH;
            end
            STEP_HOLD: begin
                w.cond   = CND_ALWAYS;
                w.target = STEP_EMIT;
            end
            default: begin
                w.cond   = CND_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] decode_key(
        logic       flag,
        logic [3:0] rows,
        logic [3:0] cols
    );
        logic [1:0]        r;
        logic [1:0]        c;
        logic              r_hit;
        logic              c_hit;
        logic [CODE_W-1:0] code;
        r     = 2'd0;
        c     = 2'd0;
        r_hit = 1'b0;
        c_hit = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            if (!rows[i]) begin
                r     = 2'(i);
                r_hit = 1'b1;
            end
            if (!cols[i]) begin
                c     = 2'(i);
                c_hit = 1'b1;
            end
        end
        code = KEY_MAP[{r, c}];
        if (!flag || !r_hit || !c_hit) begin
            code = KC_FILL;
        end
        return code;
    endfunction

endpackage

[src/kde_ram.sv]
`timescale 1ns / 1ps

module kde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 7,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kde_seq.sv]
`timescale 1ns / 1ps

module kde_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  kde_pkg::t_status i_status,
    output kde_pkg::t_ctrl   o_ctrl
);
    import kde_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w;
    logic            jump;

    always_comb begin
        w = ucode(r_pc);
        unique case (w.cond)
            CND_NEXT:      jump = 1'b0;
            CND_ALWAYS:    jump = 1'b1;
            CND_NO_INPUT:  jump = !i_in_valid;
            CND_LOOP_DONE: jump = i_status.loop_done;
            CND_OUT_FREE:  jump = i_status.out_free;
            default:       jump = 1'b1;
        endcase
        n_pc = jump ? w.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w;

endmodule

[src/kde_datapath.sv]
`timescale 1ns / 1ps

module kde_datapath #(
    parameter int MAX_CHARS = kde_pkg::KDE_MAX_CHARS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kde_pkg::t_ctrl     i_ctrl,
    input  logic               i_in_valid,
    input  kde_pkg::t_in_item  i_in_item,
    output kde_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kde_pkg::t_out_item o_out_item
);
    import kde_pkg::*;

    localparam int LW = $clog2(MAX_CHARS + 1);
    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_CHARS);

    logic [CODE_W-1:0]   r_kind;
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       n_len;
    logic [LW-1:0]       r_idx;
    logic [MANT_W-1:0]   r_mant;
    logic [PLACES_W-1:0] r_places;
    logic                r_seen;
    logic                r_confirmed;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                room;
    logic                we;
    logic [CODE_W-1:0]   wdata;
    logic [CODE_W-1:0]   rdata;
    logic                out_free;

    kde_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_CHARS)
    ) u_chars (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign room     = r_len < LEN_MAX;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        we    = 1'b0;
        wdata = KC_ZERO;
        n_len = r_len;
        if (i_ctrl.edit) begin
            priority if (r_kind <= KC_NINE && room) begin
                we    = 1'b1;
                wdata = r_kind;
                n_len = r_len + 1'b1;
            end else if (r_kind == KC_ENTER) begin
                n_len = r_len;
            end else if (r_kind == KC_BACK) begin
                if (r_len != '0) begin
                    n_len = r_len - 1'b1;
                end
            end else if (r_kind == KC_POINT && room) begin
                we    = 1'b1;
                wdata = KC_POINT;
                n_len = r_len + 1'b1;
            end else if (room) begin
                we    = 1'b1;
                wdata = KC_ZERO;
                n_len = r_len + 1'b1;
            end else begin
                n_len = r_len;
            end
        end else if (i_ctrl.emit && out_free && r_confirmed) begin
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_ctrl.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take && i_in_valid) begin
            r_kind <= decode_key(i_in_item.key_flag, i_in_item.row_lines,
                                 i_in_item.col_lines);
        end
        if (i_ctrl.edit) begin
            r_confirmed <= (r_kind == KC_ENTER);
            r_idx       <= '0;
            r_mant      <= '0;
            r_places    <= '0;
            r_seen      <= 1'b0;
        end
        if (i_ctrl.accum) begin
            r_idx    <= r_idx + 1'b1;
            r_places <= r_places + PLACES_W'(r_seen);
            if (rdata == KC_POINT) begin
                r_seen <= 1'b1;
            end else begin
                r_mant <= (r_mant << 3) + (r_mant << 1) + MANT_W'(rdata);
            end
        end
        if (i_ctrl.emit && out_free) begin
            r_out.mantissa       <= r_mant;
            r_out.decimal_places <= r_places;
            r_out.confirmed      <= r_confirmed;
            r_out.char_count     <= COUNT_W'(r_len);
        end
    end

    assign o_status.loop_done = r_idx >= r_len;
    assign o_status.out_free  = out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("entry length beyond capacity");

    a_confirm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit && out_free && r_confirmed) |=> (r_len == '0))
        else $error("confirm did not clear entry length");

    a_accum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.accum |-> (r_idx < r_len))
        else $error("accumulation read past entry length");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && !(i_ctrl.emit && out_free))
            |=> (r_out_valid && $stable(r_out)))
        else $error("held result lost or overwritten");
`endif

endmodule

[src/keypad_decimal_entry.sv]
`timescale 1ns / 1ps

// Numeric entry from a 4x4 matrix keypad.
// Input channel (i_in_valid / o_in_stall / i_in_item): one key event per
// transfer, carrying the key flag and the sampled active-low row and column
// lines. Output channel (o_out_valid / i_out_stall / o_out_item): exactly one
// result per event, giving the entry buffer as a decimal mantissa, places
// after the first point, a confirm flag and the character count.
// For each event the microcode takes the key at its fetch step, edits the
// buffer, then walks the buffer one character at a time, alternating a test
// and an accumulate step, through the registered read port of the character
// store, and loads the result at its emit step. Once the result is loaded
// the sequencer goes straight back to its fetch step; a new event is taken
// only at the fetch step, so none is taken before the last result is loaded.
// The result register parts the two sides: while it is held by i_out_stall
// the next event is still taken and worked; the sequencer waits only when it
// must load a new result over one not yet transferred.
// Reset (i_rst_n low, synchronous) empties the buffer and drops any pending
// result; the character store is not cleared, since only entries below the
// length are ever read.
module keypad_decimal_entry #(
    parameter int MAX_CHARS = kde_pkg::KDE_MAX_CHARS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kde_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kde_pkg::t_out_item o_out_item
);
    import kde_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    kde_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    kde_datapath #(
        .MAX_CHARS (MAX_CHARS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !ctrl.take;

endmodule
